// ===== src/ebe_pkg.sv =====
// Shared types, constants and request codes of the exponential blur engine.
package ebe_pkg;

  localparam int MAX_WIDTH   = 64;
  localparam int MAX_HEIGHT  = 64;
  localparam int PIXEL_BYTES = 4;
  localparam int ALPHA_BITS  = 16;
  localparam int ACC_FRAC    = 7;
  localparam int COL_BITS    = $clog2(MAX_WIDTH);
  localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
  localparam int ADDR_BITS   = COL_BITS + ROW_BITS;
  localparam int DEPTH       = MAX_WIDTH * MAX_HEIGHT;
  localparam int DIM_BITS    = 7;
  localparam int ACC_BITS    = 16;
  localparam int CFG_BITS    = 16;
  localparam int CIDX_BITS   = 2;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_RUN   = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [CIDX_BITS-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CIDX_BITS-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CIDX_BITS-1:0] CFG_ALPHA  = 2'd2;
  localparam logic [CIDX_BITS-1:0] CFG_ENABLE = 2'd3;

  localparam logic [DIM_BITS-1:0]   WIDTH_RST  = 7'd64;
  localparam logic [DIM_BITS-1:0]   HEIGHT_RST = 7'd64;
  localparam logic [ALPHA_BITS-1:0] ALPHA_RST  = 16'd44788;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [COL_BITS-1:0] col;
    logic [ROW_BITS-1:0] row;
    logic [31:0]         pixel_in;
  } req_t;

  typedef struct packed {
    logic [31:0] pixel_out;
    logic        done_res;
  } rsp_t;

  typedef struct packed {
    logic [DIM_BITS-1:0]   width;
    logic [DIM_BITS-1:0]   height;
    logic [ALPHA_BITS-1:0] alpha;
    logic                  enable;
  } cfg_t;

  typedef struct packed {
    logic                 rd_en;
    logic [ADDR_BITS-1:0] rd_addr;
    logic                 wr_en;
    logic [ADDR_BITS-1:0] wr_addr;
    logic [31:0]          wr_data;
  } mem_cmd_t;

  typedef struct packed {
    logic seed;
    logic mul;
    logic wb;
  } filt_ctl_t;

endpackage

// ===== src/ebe_store.sv =====
// Image store: one write port and one registered read port.
module ebe_store (
  input  logic                clk,
  input  ebe_pkg::mem_cmd_t   cmd,
  output logic [31:0]         rd_data
);

  logic [31:0] mem [ebe_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= cmd.wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[cmd.rd_addr];
    end
  end

endmodule

// ===== src/ebe_filter.sv =====
// Per-channel one-pole filter datapath with its accumulators and product registers.
module ebe_filter (
  input  logic                                clk,
  input  logic                                rst,
  input  ebe_pkg::filt_ctl_t                  ctl,
  input  logic [ebe_pkg::ALPHA_BITS-1:0]      alpha,
  input  logic [31:0]                         rd_data,
  output logic [31:0]                         wr_data
);

  localparam int PROD_BITS = ebe_pkg::ALPHA_BITS + ebe_pkg::ACC_BITS + 2;
  localparam int Q_BITS    = PROD_BITS - ebe_pkg::ALPHA_BITS;
  localparam int SUM_BITS  = ebe_pkg::ACC_BITS + 3;

  logic [ebe_pkg::ACC_BITS-1:0]  acc      [ebe_pkg::PIXEL_BYTES];
  logic [ebe_pkg::ACC_BITS-1:0]  acc_next [ebe_pkg::PIXEL_BYTES];
  logic [ebe_pkg::ACC_BITS-1:0]  seed_val [ebe_pkg::PIXEL_BYTES];
  logic signed [PROD_BITS-1:0]   prod      [ebe_pkg::PIXEL_BYTES];
  logic signed [PROD_BITS-1:0]   prod_next [ebe_pkg::PIXEL_BYTES];

  always_comb begin
    logic signed [ebe_pkg::ACC_BITS:0] diff;
    logic signed [Q_BITS-1:0]          q;
    logic signed [SUM_BITS-1:0]        sum;
    wr_data = '0;
    for (int k = 0; k < ebe_pkg::PIXEL_BYTES; k++) begin
      seed_val[k] = {1'b0, rd_data[8*k +: 8], {ebe_pkg::ACC_FRAC{1'b0}}};
      diff = $signed({1'b0, seed_val[k]}) - $signed({1'b0, acc[k]});
      prod_next[k] = $signed({1'b0, alpha}) * diff;
      q = prod[k][PROD_BITS-1:ebe_pkg::ALPHA_BITS];
      sum = $signed({3'b000, acc[k]}) + $signed({q[Q_BITS-1], q});
      if (sum < 0) begin
        acc_next[k] = '0;
      end else if (sum > $signed({3'b000, {ebe_pkg::ACC_BITS{1'b1}}})) begin
        acc_next[k] = '1;
      end else begin
        acc_next[k] = sum[ebe_pkg::ACC_BITS-1:0];
      end
      wr_data[8*k +: 8] = acc_next[k][ebe_pkg::ACC_FRAC +: 8];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < ebe_pkg::PIXEL_BYTES; k++) begin
      if (ctl.mul) begin
        prod[k] <= prod_next[k];
      end
      if (rst) begin
        acc[k] <= '0;
      end else if (ctl.seed) begin
        acc[k] <= seed_val[k];
      end else if (ctl.wb) begin
        acc[k] <= acc_next[k];
      end
    end
  end

endmodule

// ===== src/ebe_ctrl.sv =====
// Request sequencer: pixel access, blur pass walk and result hand-off.
module ebe_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  ebe_pkg::req_t       req,
  output logic                req_stall,
  input  ebe_pkg::cfg_t       cfg,
  input  logic                rsp_free,
  output logic                rsp_load,
  output ebe_pkg::rsp_t       rsp_word,
  output ebe_pkg::mem_cmd_t   mem_cmd,
  input  logic [31:0]         rd_data,
  output ebe_pkg::filt_ctl_t  fctl,
  input  logic [31:0]         filt_data
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_RDWAIT = 7'b0000010,
    S_REPLY  = 7'b0000100,
    S_ISSUE  = 7'b0001000,
    S_SEED   = 7'b0010000,
    S_MUL    = 7'b0100000,
    S_WB     = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  logic                          col_pass;
  logic [ebe_pkg::ROW_BITS-1:0]  outer;
  logic signed [7:0]             inner;
  logic                          bwd;
  logic                          seed_pend;
  logic [31:0]                   res_pix;
  logic                          res_done;

  logic [ebe_pkg::DIM_BITS-1:0]  w_eff;
  logic [ebe_pkg::DIM_BITS-1:0]  h_eff;
  logic [ebe_pkg::DIM_BITS-1:0]  len_o;
  logic [ebe_pkg::DIM_BITS-1:0]  len_i;
  logic signed [7:0]             fwd_last;
  logic signed [7:0]             bwd_first;
  logic                          accept;
  logic                          fwd_over;
  logic                          bwd_over;
  logic                          last_line;
  logic                          issue_rd;
  logic [ebe_pkg::ADDR_BITS-1:0] req_addr;
  logic [ebe_pkg::ADDR_BITS-1:0] cur_addr;
  logic [ebe_pkg::ADDR_BITS-1:0] seed_addr;

  assign w_eff = (cfg.width > ebe_pkg::DIM_BITS'(ebe_pkg::MAX_WIDTH))
               ? ebe_pkg::DIM_BITS'(ebe_pkg::MAX_WIDTH) : cfg.width;
  assign h_eff = (cfg.height > ebe_pkg::DIM_BITS'(ebe_pkg::MAX_HEIGHT))
               ? ebe_pkg::DIM_BITS'(ebe_pkg::MAX_HEIGHT) : cfg.height;
  assign len_o = col_pass ? w_eff : h_eff;
  assign len_i = col_pass ? h_eff : w_eff;
  assign bwd_first = $signed({1'b0, len_i}) - 8'sd2;
  assign fwd_last  = col_pass ? bwd_first : ($signed({1'b0, len_i}) - 8'sd1);
  assign fwd_over  = !bwd && (inner > fwd_last);
  assign bwd_over  = bwd && (inner < 8'sd0);
  assign last_line = ({1'b0, outer} == (len_o - 7'd1));
  assign issue_rd  = (state == S_ISSUE) && (seed_pend || (!fwd_over && !bwd_over));

  assign accept    = req_valid && (state == S_IDLE);
  assign req_stall = (state != S_IDLE);
  assign req_addr  = {req.row, req.col};
  assign cur_addr  = col_pass ? {inner[ebe_pkg::ROW_BITS-1:0], outer}
                              : {outer, inner[ebe_pkg::COL_BITS-1:0]};
  assign seed_addr = col_pass ? {{ebe_pkg::ROW_BITS{1'b0}}, outer}
                              : {outer, {ebe_pkg::COL_BITS{1'b0}}};

  assign rsp_load           = (state == S_REPLY) && rsp_free;
  assign rsp_word.pixel_out = res_pix;
  assign rsp_word.done_res  = res_done;

  assign fctl.seed = (state == S_SEED);
  assign fctl.mul  = (state == S_MUL);
  assign fctl.wb   = (state == S_WB);

  always_comb begin
    mem_cmd.rd_en   = (accept && req.req_type == ebe_pkg::REQ_READ) || issue_rd;
    mem_cmd.rd_addr = (state == S_IDLE) ? req_addr : (seed_pend ? seed_addr : cur_addr);
    mem_cmd.wr_en   = (accept && req.req_type == ebe_pkg::REQ_WRITE) || (state == S_WB);
    mem_cmd.wr_addr = (state == S_IDLE) ? req_addr : cur_addr;
    mem_cmd.wr_data = (state == S_IDLE) ? req.pixel_in : filt_data;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.req_type == ebe_pkg::REQ_READ) begin
            state_next = S_RDWAIT;
          end else if (req.req_type == ebe_pkg::REQ_RUN && cfg.enable &&
                       w_eff != '0 && h_eff != '0) begin
            state_next = S_ISSUE;
          end else begin
            state_next = S_REPLY;
          end
        end
      end
      S_RDWAIT: state_next = S_REPLY;
      S_REPLY: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      S_ISSUE: begin
        if (seed_pend) begin
          state_next = S_SEED;
        end else if (bwd_over && last_line && col_pass) begin
          state_next = S_REPLY;
        end else if (!fwd_over && !bwd_over) begin
          state_next = S_MUL;
        end
      end
      S_SEED:  state_next = S_ISSUE;
      S_MUL:   state_next = S_WB;
      S_WB:    state_next = S_ISSUE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          res_pix   <= '0;
          res_done  <= (req.req_type == ebe_pkg::REQ_WRITE) ||
                       (req.req_type == ebe_pkg::REQ_RUN) ||
                       (req.req_type == ebe_pkg::REQ_READ);
          col_pass  <= 1'b0;
          outer     <= '0;
          inner     <= '0;
          bwd       <= 1'b0;
          seed_pend <= 1'b1;
        end
      end
      S_RDWAIT: res_pix <= rd_data;
      S_ISSUE: begin
        if (!seed_pend) begin
          if (fwd_over) begin
            bwd   <= 1'b1;
            inner <= bwd_first;
          end else if (bwd_over) begin
            seed_pend <= 1'b1;
            if (last_line) begin
              col_pass <= 1'b1;
              outer    <= '0;
            end else begin
              outer <= outer + 1'b1;
            end
          end
        end
      end
      S_SEED: begin
        seed_pend <= 1'b0;
        bwd       <= 1'b0;
        inner     <= col_pass ? 8'sd1 : 8'sd0;
      end
      S_WB: inner <= bwd ? (inner - 8'sd1) : (inner + 8'sd1);
      S_REPLY, S_MUL: begin
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== src/exponential_blur_engine.sv =====
// Top level of the exponential blur engine: configuration, store, filter and result register.
//
// Requests arrive on the req channel (req_valid, req_stall, req); each accepted word
// gives exactly one result word on the rsp channel (rsp_valid, rsp_stall, rsp).
// A write request stores one pixel, a read request returns one pixel, and an enabled run
// request blurs the configured region of the image before it answers.
// Requests are handled one at a time. A write goes straight to its answer, while a read
// first waits for the store's registered read; the next request is taken in the cycle
// after the answer is loaded into the result register, even while that result is still
// held there. A run request walks every row and then every column; each filtered pixel
// passes through the store's read, multiply and write-back loop, and each line is also
// seeded and turned round, before the run answers. Configuration is written through
// cfg_we, cfg_index and cfg_data; the user must do so only while the block is idle,
// which the block itself does not enforce.
// Synchronous reset returns the registers to their defaults and empties the result
// register; the image store is not cleared, and a pixel never written reads back
// undefined. While the receiver stalls, the result word is held and no further
// request is taken after the next one.
module exponential_blur_engine (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  ebe_pkg::req_t                   req,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output ebe_pkg::rsp_t                   rsp,
  input  logic                            cfg_we,
  input  logic [ebe_pkg::CIDX_BITS-1:0]   cfg_index,
  input  logic [ebe_pkg::CFG_BITS-1:0]    cfg_data
);

  ebe_pkg::cfg_t      cfg;
  ebe_pkg::mem_cmd_t  mem_cmd;
  ebe_pkg::filt_ctl_t fctl;
  ebe_pkg::rsp_t      rsp_word;
  logic [31:0]        rd_data;
  logic [31:0]        filt_data;
  logic               rsp_free;
  logic               rsp_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width  <= ebe_pkg::WIDTH_RST;
      cfg.height <= ebe_pkg::HEIGHT_RST;
      cfg.alpha  <= ebe_pkg::ALPHA_RST;
      cfg.enable <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ebe_pkg::CFG_WIDTH:  cfg.width  <= cfg_data[ebe_pkg::DIM_BITS-1:0];
        ebe_pkg::CFG_HEIGHT: cfg.height <= cfg_data[ebe_pkg::DIM_BITS-1:0];
        ebe_pkg::CFG_ALPHA:  cfg.alpha  <= cfg_data[ebe_pkg::ALPHA_BITS-1:0];
        ebe_pkg::CFG_ENABLE: cfg.enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign rsp_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= rsp_word;
    end
  end

  ebe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .req_stall (req_stall),
    .cfg       (cfg),
    .rsp_free  (rsp_free),
    .rsp_load  (rsp_load),
    .rsp_word  (rsp_word),
    .mem_cmd   (mem_cmd),
    .rd_data   (rd_data),
    .fctl      (fctl),
    .filt_data (filt_data)
  );

  ebe_store u_store (
    .clk     (clk),
    .cmd     (mem_cmd),
    .rd_data (rd_data)
  );

  ebe_filter u_filter (
    .clk     (clk),
    .rst     (rst),
    .ctl     (fctl),
    .alpha   (cfg.alpha),
    .rd_data (rd_data),
    .wr_data (filt_data)
  );

endmodule

// ===== tb/sv/ebe_checker.sv =====
// Checker for the exponential blur engine: predicts every result word and compares it.
module ebe_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  input  logic                          req_stall,
  input  ebe_pkg::req_t                 req,
  input  logic                          rsp_valid,
  input  logic                          rsp_stall,
  input  ebe_pkg::rsp_t                 rsp,
  input  logic                          cfg_we,
  input  logic [ebe_pkg::CIDX_BITS-1:0] cfg_index,
  input  logic [ebe_pkg::CFG_BITS-1:0]  cfg_data,
  output int unsigned                   fail_count,
  output int unsigned                   awaited,
  output int unsigned                   checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import ebe_pkg::*;

  logic [31:0]           image [DEPTH];
  logic [ACC_BITS-1:0]   acc [PIXEL_BYTES];
  logic [DIM_BITS-1:0]   cur_width;
  logic [DIM_BITS-1:0]   cur_height;
  logic [ALPHA_BITS-1:0] cur_alpha;
  logic                  cur_enable;
  rsp_t                  answers [$];

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      image[i] = '0;
    end
  end

  function automatic void seed_from(int addr);
    for (int k = 0; k < PIXEL_BYTES; k++) begin
      acc[k] = {1'b0, image[addr][8*k +: 8], 7'b0};
    end
  endfunction

  function automatic void smooth_at(int addr);
    logic [31:0] px;
    logic [31:0] res;
    longint      target;
    longint      z;
    longint      p;
    px = image[addr];
    res = '0;
    for (int k = 0; k < PIXEL_BYTES; k++) begin
      target = longint'(px[8*k +: 8]) << ACC_FRAC;
      z = longint'(acc[k]);
      p = longint'(cur_alpha) * (target - z);
      z = z + (p >>> ALPHA_BITS);
      if (z < 0) begin
        z = 0;
      end
      if (z > 65535) begin
        z = 65535;
      end
      acc[k] = z[ACC_BITS-1:0];
      res[8*k +: 8] = z[ACC_FRAC +: 8];
    end
    image[addr] = res;
  endfunction

  function automatic void blur_image();
    int w;
    int h;
    int base;
    w = (cur_width > MAX_WIDTH) ? MAX_WIDTH : int'(cur_width);
    h = (cur_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(cur_height);
    if (w == 0 || h == 0) begin
      return;
    end
    for (int r = 0; r < h; r++) begin
      base = r * MAX_WIDTH;
      seed_from(base);
      for (int c = 0; c < w; c++) begin
        smooth_at(base + c);
      end
      for (int c = w - 2; c >= 0; c--) begin
        smooth_at(base + c);
      end
    end
    for (int c = 0; c < w; c++) begin
      seed_from(c);
      for (int r = 1; r < h - 1; r++) begin
        smooth_at(r * MAX_WIDTH + c);
      end
      for (int r = h - 2; r >= 0; r--) begin
        smooth_at(r * MAX_WIDTH + c);
      end
    end
  endfunction

  function automatic rsp_t answer_for(req_t w);
    rsp_t a;
    int   addr;
    a.pixel_out = '0;
    a.done_res = 1'b1;
    addr = int'({w.row, w.col});
    case (w.req_type)
      REQ_WRITE: begin
        image[addr] = w.pixel_in;
      end
      REQ_RUN: begin
        if (cur_enable) begin
          blur_image();
        end
      end
      REQ_READ: begin
        a.pixel_out = image[addr];
      end
      default: begin
        a.done_res = 1'b0;
      end
    endcase
    return a;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      cur_width = WIDTH_RST;
      cur_height = HEIGHT_RST;
      cur_alpha = ALPHA_RST;
      cur_enable = 1'b1;
      for (int k = 0; k < PIXEL_BYTES; k++) begin
        acc[k] = '0;
      end
      answers.delete();
      fail_count = 0;
      checked = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WIDTH:  cur_width = cfg_data[DIM_BITS-1:0];
          CFG_HEIGHT: cur_height = cfg_data[DIM_BITS-1:0];
          CFG_ALPHA:  cur_alpha = cfg_data[ALPHA_BITS-1:0];
          CFG_ENABLE: cur_enable = cfg_data[0];
          default: ;
        endcase
      end
      if (rsp_valid && !rsp_stall) begin
        if (answers.size() == 0) begin
          fail_count++;
          $error("result word with nothing outstanding: pixel_out %h, done_res %b",
                 rsp.pixel_out, rsp.done_res);
        end else begin
          want = answers.pop_front();
          checked++;
          if (rsp.pixel_out !== want.pixel_out) begin
            fail_count++;
            $error("pixel_out: expected %h, actual %h", want.pixel_out, rsp.pixel_out);
          end
          if (rsp.done_res !== want.done_res) begin
            fail_count++;
            $error("done_res: expected %b, actual %b", want.done_res, rsp.done_res);
          end
        end
      end
      if (req_valid && !req_stall) begin
        answers.push_back(answer_for(req));
      end
    end
    awaited = answers.size();
  end

endmodule

// ===== tb/sv/tb_exponential_blur_engine.sv =====
// Top of the blur engine testbench: clock, reset, request and configuration stimulus, verdict.
module tb_exponential_blur_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import ebe_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned ITEMS = 1675;
  localparam int unsigned LIMIT = 3000000;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 req_valid;
  logic                 req_stall;
  req_t                 req;
  logic                 rsp_valid;
  logic                 rsp_stall;
  rsp_t                 rsp;
  logic                 cfg_we;
  logic [CIDX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]  cfg_data;
  int unsigned          fail_count;
  int unsigned          awaited;
  int unsigned          checked;

  int unsigned          cycles;
  int unsigned          n_items;
  int unsigned          n_reads;
  int unsigned          n_runs;
  int unsigned          n_settings;
  int unsigned          quiet_left;
  bit                   written [DEPTH];
  int                   written_at [$];
  int                   sh_width;
  int                   sh_height;
  bit                   sh_enable;

  exponential_blur_engine DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ebe_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .awaited    (awaited),
    .checked    (checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    int unsigned n;
    rsp_stall = 1'b0;
    forever begin
      case ($urandom_range(0, 9))
        0:       n = $urandom_range(100, 300);
        1, 2:    n = $urandom_range(5, 20);
        default: n = $urandom_range(1, 4);
      endcase
      repeat (n) @(negedge clk);
      rsp_stall <= 1'b1;
      case ($urandom_range(0, 19))
        0:          n = $urandom_range(30, 60);
        1, 2, 3, 4: n = $urandom_range(3, 10);
        default:    n = $urandom_range(1, 2);
      endcase
      repeat (n) @(negedge clk);
      rsp_stall <= 1'b0;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (quiet_left != 0) begin
      quiet_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) quiet_left = $urandom_range(20, 80);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  function automatic logic [31:0] rand_pixel();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = '1;
      2: begin
        for (int k = 0; k < PIXEL_BYTES; k++) begin
          v[8*k +: 8] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        end
      end
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_req(input logic [1:0] kind, input int c, input int r,
                          input logic [31:0] px);
    int unsigned gap;
    req_t        w;
    gap = pick_gap();
    w.req_type = kind;
    w.col = c[COL_BITS-1:0];
    w.row = r[ROW_BITS-1:0];
    w.pixel_in = px;
    @(negedge clk);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    n_items++;
  endtask

  task automatic write_px(input int c, input int r, input logic [31:0] px);
    int addr;
    addr = r * MAX_WIDTH + c;
    send_req(REQ_WRITE, c, r, px);
    if (!written[addr]) begin
      written[addr] = 1'b1;
      written_at.push_back(addr);
    end
  endtask

  task automatic read_px(input int c, input int r);
    send_req(REQ_READ, c, r, $urandom);
    n_reads++;
  endtask

  task automatic read_any();
    int addr;
    addr = written_at[$urandom_range(0, written_at.size() - 1)];
    read_px(addr % MAX_WIDTH, addr / MAX_WIDTH);
  endtask

  function automatic int used_width();
    return (sh_width > MAX_WIDTH) ? MAX_WIDTH : sh_width;
  endfunction

  function automatic int used_height();
    return (sh_height > MAX_HEIGHT) ? MAX_HEIGHT : sh_height;
  endfunction

  // A blur may only touch pixels that hold data, so any gap in the region is filled first.
  task automatic run_blur();
    if (sh_enable) begin
      for (int r = 0; r < used_height(); r++) begin
        for (int c = 0; c < used_width(); c++) begin
          if (!written[r * MAX_WIDTH + c]) write_px(c, r, rand_pixel());
        end
      end
    end
    send_req(REQ_RUN, $urandom, $urandom, $urandom);
    n_runs++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    req_valid <= 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic set_config(input int w, input int h, input int a, input bit en);
    logic [CFG_BITS-1:0] d;
    wait_idle();
    d = CFG_BITS'($urandom);
    d[DIM_BITS-1:0] = w[DIM_BITS-1:0];
    cfg_we <= 1'b1;
    cfg_index <= CFG_WIDTH;
    cfg_data <= d;
    @(negedge clk);
    d = CFG_BITS'($urandom);
    d[DIM_BITS-1:0] = h[DIM_BITS-1:0];
    cfg_index <= CFG_HEIGHT;
    cfg_data <= d;
    @(negedge clk);
    cfg_index <= CFG_ALPHA;
    cfg_data <= a[CFG_BITS-1:0];
    @(negedge clk);
    d = CFG_BITS'($urandom);
    d[0] = en;
    cfg_index <= CFG_ENABLE;
    cfg_data <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    sh_width = w & 32'h7F;
    sh_height = h & 32'h7F;
    sh_enable = en;
    n_settings++;
  endtask

  initial begin
    int          w;
    int          h;
    int          a;
    int unsigned roll;
    int unsigned steps;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    n_items = 0;
    n_reads = 0;
    n_runs = 0;
    n_settings = 0;
    quiet_left = 0;
    sh_width = WIDTH_RST;
    sh_height = HEIGHT_RST;
    sh_enable = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_px(0, 0, 32'h0000_0000);
    write_px(MAX_WIDTH - 1, MAX_HEIGHT - 1, 32'hFFFF_FFFF);
    write_px(MAX_WIDTH - 1, 0, $urandom);
    write_px(0, MAX_HEIGHT - 1, 32'hFF00_00FF);
    read_px(0, 0);
    read_px(MAX_WIDTH - 1, MAX_HEIGHT - 1);
    read_px(MAX_WIDTH - 1, 0);
    read_px(0, MAX_HEIGHT - 1);
    send_req(REQ_UNUSED, MAX_WIDTH - 1, MAX_HEIGHT - 1, 32'hFFFF_FFFF);

    set_config(2, 2, 65535, 1'b1);
    write_px(1, 0, 32'hFF00_FF00);
    write_px(0, 1, 32'h00FF_00FF);
    write_px(1, 1, 32'hFFFF_FFFF);
    run_blur();
    read_px(0, 0);
    read_px(1, 0);
    read_px(0, 1);
    read_px(1, 1);
    set_config(2, 2, 0, 1'b1);
    run_blur();
    read_px(1, 1);
    set_config(2, 2, ALPHA_RST, 1'b0);
    run_blur();
    read_px(0, 0);
    set_config(0, 3, ALPHA_RST, 1'b1);
    run_blur();
    set_config(3, 0, ALPHA_RST, 1'b1);
    run_blur();
    read_px(1, 0);

    while (n_items < ITEMS) begin
      case ($urandom_range(0, 19))
        0: begin
          w = MAX_WIDTH;
          h = $urandom_range(1, 3);
        end
        1: begin
          w = $urandom_range(1, 3);
          h = MAX_HEIGHT;
        end
        2: begin
          w = $urandom_range(MAX_WIDTH + 1, 127);
          h = $urandom_range(1, 2);
        end
        3: begin
          w = $urandom_range(1, 2);
          h = $urandom_range(MAX_HEIGHT + 1, 127);
        end
        4: begin
          w = $urandom_range(0, 1) * $urandom_range(1, 8);
          h = (w == 0) ? $urandom_range(0, 8) : 0;
        end
        default: begin
          w = $urandom_range(1, 8);
          h = $urandom_range(1, 8);
        end
      endcase
      case ($urandom_range(0, 7))
        0:       a = 0;
        1:       a = 65535;
        2:       a = ALPHA_RST;
        default: a = $urandom_range(0, 65535);
      endcase
      set_config(w, h, a, $urandom_range(0, 9) != 0);
      if ($urandom_range(0, 1) != 0) run_blur();
      steps = $urandom_range(15, 40);
      repeat (steps) begin
        roll = $urandom_range(0, 99);
        if (roll < 42) begin
          if (roll < 34 && used_width() > 0 && used_height() > 0) begin
            write_px($urandom_range(0, used_width() - 1), $urandom_range(0, used_height() - 1),
                     rand_pixel());
          end else begin
            write_px($urandom_range(0, MAX_WIDTH - 1), $urandom_range(0, MAX_HEIGHT - 1),
                     rand_pixel());
          end
        end else if (roll < 84) begin
          read_any();
        end else if (roll < 95) begin
          run_blur();
        end else begin
          send_req(REQ_UNUSED, $urandom, $urandom, $urandom);
        end
      end
    end

    @(negedge clk);
    req_valid <= 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("summary: %0d request words (%0d reads, %0d blurs) over %0d register settings,",
             n_items, n_reads, n_runs, n_settings);
    $display("summary: regions from empty to 64 pixels a side, %0d result words checked",
             checked);
    if (fail_count == 0 && awaited == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== exponential_blur_engine.f =====
src/ebe_pkg.sv
src/ebe_store.sv
src/ebe_filter.sv
src/ebe_ctrl.sv
src/exponential_blur_engine.sv
tb/sv/ebe_checker.sv
tb/sv/tb_exponential_blur_engine.sv
